>>> src/nalr_pkg.sv
// ============================================================================
// nalr_pkg: shared types and constants of the NAL escape-removing bit reader
// Request kinds, result status codes, pending request codes and store sizes.
// ============================================================================
package nalr_pkg;

  // Bit store size and skip length width.
  localparam int STORE_BITS    = 64;
  localparam int COUNT_BITS    = 16;
  localparam int HELD_BITS     = $clog2(STORE_BITS + 1);
  localparam int MAX_READ_BITS = 32;
  localparam int BYTE_BITS     = 8;

  // Emulation prevention byte and the zero run that arms it.
  localparam logic [7:0] ESCAPE_BYTE = 8'h03;
  localparam logic [1:0] ZERO_RUN_MAX = 2'd2;

  // Request word kinds.
  typedef enum logic [2:0] {
    KIND_BYTE    = 3'd0,
    KIND_READ    = 3'd1,
    KIND_SKIP    = 3'd2,
    KIND_END     = 3'd3,
    KIND_RESTART = 3'd4
  } kind_t;

  // Result word status codes.
  typedef enum logic [2:0] {
    STATUS_READ_DONE = 3'd0,
    STATUS_SKIP_DONE = 3'd1,
    STATUS_OVERREAD  = 3'd2,
    STATUS_TOO_WIDE  = 3'd3,
    STATUS_FULL      = 3'd4,
    STATUS_BUSY      = 3'd5
  } status_t;

  // Request waiting for more stream bytes.
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_READ = 2'd1,
    PEND_SKIP = 2'd2
  } pend_t;

endpackage

>>> src/nalr_ifs.sv
// ============================================================================
// nalr interfaces: request, result and configuration channels
// Each channel carries valid, ready and its payload, with source and sink views.
// ============================================================================

// Request channel: stream bytes, reads, skips, end of data and restart.
interface nalr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  byte_value;
  logic [15:0] bit_count;

  modport source (output valid, kind, byte_value, bit_count, input ready);
  modport sink   (input valid, kind, byte_value, bit_count, output ready);
endinterface

// Result channel: status, read value and bits still held.
interface nalr_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] value;
  logic [6:0]  bits_held;

  modport source (output valid, status, value, bits_held, input ready);
  modport sink   (input valid, status, value, bits_held, output ready);
endinterface

// Configuration channel: the escape removal enable.
interface nalr_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> src/nal_escape_removing_bit_reader.sv
// ============================================================================
// nal_escape_removing_bit_reader: MSB-first bit reader for NAL unit payloads
// Drops emulation prevention bytes and serves reads and skips from a bit store.
// ============================================================================
// Usage:
//   req carries one word per handshake: a stream byte, a read of 0 to 32 bits,
//   a skip, an end-of-data mark or a restart. rsp returns at most one word per
//   request word: a status code, the bits read and the count of bits held.
//   cfg writes the escape removal enable; it is always ready. The user must
//   write it only while the reader is idle; the block itself does not enforce it.
//   A request word is latched in an input register and processed from there;
//   its result goes into the result register, from which it can be taken.
//   One word is taken every cycle while rsp does not stall; the bit store,
//   counters and pending request are updated together for each word.
//   A read or skip that the store cannot cover yet waits; it is answered by the
//   byte word that completes it, or fails at end of data.
//   When rsp stalls, the result register holds its word and the input register
//   still takes one more word; req.ready then drops until the result leaves.
//   Reset empties the store, clears the pending request and flags, and turns
//   escape removal on. A restart word does the same but keeps the enable.
// ============================================================================
module nal_escape_removing_bit_reader (
  input  logic            clk,
  input  logic            rst,
  nalr_req_if.sink        req,
  nalr_rsp_if.source      rsp,
  nalr_cfg_if.sink        cfg
);
  import nalr_pkg::*;

  // Input register.
  logic                   item_valid;
  kind_t                  item_kind;
  logic [7:0]             item_byte;
  logic [15:0]            item_count;

  // Reader state.
  logic [STORE_BITS-1:0]  store;
  logic [HELD_BITS-1:0]   held;
  logic [1:0]             zero_run;
  logic                   overread;
  logic                   end_seen;
  pend_t                  pend_op;
  logic [COUNT_BITS-1:0]  pend_bits;
  logic                   esc_on;

  // Next state and result.
  logic [STORE_BITS-1:0]  store_next;
  logic [HELD_BITS-1:0]   held_next;
  logic [1:0]             zero_run_next;
  logic                   overread_next;
  logic                   end_seen_next;
  pend_t                  pend_op_next;
  logic [COUNT_BITS-1:0]  pend_bits_next;
  logic                   emit;
  status_t                emit_status;
  logic [31:0]            emit_value;

  // Working values.
  logic [STORE_BITS-1:0]  app_store;
  logic [HELD_BITS-1:0]   app_held;
  logic [COUNT_BITS-1:0]  cnt;

  // Result register.
  logic                   rsp_valid;
  status_t                rsp_status;
  logic [31:0]            rsp_value;
  logic [6:0]             rsp_bits_held;

  logic                   adv;

  // Leading n bits of the store, right aligned; n is at most 32.
  function automatic logic [31:0] take_value(logic [STORE_BITS-1:0] s,
                                             logic [HELD_BITS-1:0] n);
    logic [HELD_BITS-1:0] sh;
    sh = HELD_BITS'(STORE_BITS) - n;
    return 32'(s >> sh);
  endfunction

  // Handshakes.
  assign adv       = item_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !item_valid || adv;
  assign cfg.ready = 1'b1;

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.value     = rsp_value;
  assign rsp.bits_held = rsp_bits_held;

  // Byte appended at the end of the held bits.
  assign app_store = store | ((STORE_BITS'(item_byte) << (STORE_BITS - BYTE_BITS)) >> held);
  assign app_held  = held + HELD_BITS'(BYTE_BITS);
  assign cnt       = item_count[COUNT_BITS-1:0];

  // Next state and result for the word in the input register.
  always_comb begin
    store_next     = store;
    held_next      = held;
    zero_run_next  = zero_run;
    overread_next  = overread;
    end_seen_next  = end_seen;
    pend_op_next   = pend_op;
    pend_bits_next = pend_bits;
    emit           = 1'b0;
    emit_status    = STATUS_READ_DONE;
    emit_value     = '0;
    case (item_kind)
      KIND_BYTE: begin
        if (end_seen) begin
          // Bytes after end of data are ignored until a restart.
        end else if (esc_on && zero_run >= ZERO_RUN_MAX && item_byte == ESCAPE_BYTE) begin
          zero_run_next = '0;
        end else if (held > HELD_BITS'(STORE_BITS - BYTE_BITS)) begin
          emit        = 1'b1;
          emit_status = STATUS_FULL;
        end else begin
          if (item_byte == 8'h00) begin
            if (zero_run < ZERO_RUN_MAX) zero_run_next = zero_run + 2'd1;
          end else begin
            zero_run_next = '0;
          end
          store_next = app_store;
          held_next  = app_held;
          // Serve a waiting request from the grown store.
          if (pend_op == PEND_READ) begin
            if (COUNT_BITS'(app_held) >= pend_bits) begin
              emit_value     = take_value(app_store, HELD_BITS'(pend_bits));
              store_next     = app_store << pend_bits;
              held_next      = app_held - HELD_BITS'(pend_bits);
              pend_op_next   = PEND_NONE;
              pend_bits_next = '0;
              emit           = 1'b1;
              emit_status    = STATUS_READ_DONE;
            end
          end else if (pend_op == PEND_SKIP) begin
            if (pend_bits <= COUNT_BITS'(app_held)) begin
              store_next     = app_store << pend_bits;
              held_next      = app_held - HELD_BITS'(pend_bits);
              pend_op_next   = PEND_NONE;
              pend_bits_next = '0;
              emit           = 1'b1;
              emit_status    = STATUS_SKIP_DONE;
            end else begin
              store_next     = '0;
              held_next      = '0;
              pend_bits_next = pend_bits - COUNT_BITS'(app_held);
            end
          end
        end
      end
      KIND_READ, KIND_SKIP: begin
        emit = 1'b1;
        if (item_kind == KIND_READ && item_count > 16'(MAX_READ_BITS)) begin
          emit_status = STATUS_TOO_WIDE;
        end else if (pend_op != PEND_NONE) begin
          emit_status = STATUS_BUSY;
        end else if (cnt == '0) begin
          emit_status = (item_kind == KIND_READ) ? STATUS_READ_DONE : STATUS_SKIP_DONE;
        end else if (overread) begin
          emit_status = STATUS_OVERREAD;
        end else if (cnt <= COUNT_BITS'(held)) begin
          // Enough bits held: answer at once.
          if (item_kind == KIND_READ) begin
            emit_value  = take_value(store, HELD_BITS'(cnt));
            emit_status = STATUS_READ_DONE;
          end else begin
            emit_status = STATUS_SKIP_DONE;
          end
          store_next = store << cnt;
          held_next  = held - HELD_BITS'(cnt);
        end else if (end_seen) begin
          store_next    = '0;
          held_next     = '0;
          overread_next = 1'b1;
          emit_status   = STATUS_OVERREAD;
        end else begin
          // Not enough bits yet: the request waits; a skip eats what is held.
          emit           = 1'b0;
          pend_bits_next = cnt;
          if (item_kind == KIND_READ) begin
            pend_op_next = PEND_READ;
          end else begin
            pend_op_next   = PEND_SKIP;
            pend_bits_next = cnt - COUNT_BITS'(held);
            store_next     = '0;
            held_next      = '0;
          end
        end
      end
      KIND_END: begin
        end_seen_next = 1'b1;
        if (pend_op != PEND_NONE) begin
          store_next     = '0;
          held_next      = '0;
          overread_next  = 1'b1;
          pend_op_next   = PEND_NONE;
          pend_bits_next = '0;
          emit           = 1'b1;
          emit_status    = STATUS_OVERREAD;
        end
      end
      KIND_RESTART: begin
        store_next     = '0;
        held_next      = '0;
        zero_run_next  = '0;
        overread_next  = 1'b0;
        end_seen_next  = 1'b0;
        pend_op_next   = PEND_NONE;
        pend_bits_next = '0;
      end
      default: begin
        // Unused kinds are ignored.
      end
    endcase
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      item_valid <= 1'b1;
    end else if (adv) begin
      item_valid <= 1'b0;
    end
    if (req.valid && req.ready) begin
      item_kind  <= kind_t'(req.kind);
      item_byte  <= req.byte_value;
      item_count <= req.bit_count;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      esc_on <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      esc_on <= cfg.data;
    end
  end

  // Reader state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      store     <= '0;
      held      <= '0;
      zero_run  <= '0;
      overread  <= 1'b0;
      end_seen  <= 1'b0;
      pend_op   <= PEND_NONE;
      pend_bits <= '0;
    end else if (adv) begin
      store     <= store_next;
      held      <= held_next;
      zero_run  <= zero_run_next;
      overread  <= overread_next;
      end_seen  <= end_seen_next;
      pend_op   <= pend_op_next;
      pend_bits <= pend_bits_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv && emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (adv && emit) begin
      rsp_status    <= emit_status;
      rsp_value     <= emit_value;
      rsp_bits_held <= 7'(held_next);
    end
  end

endmodule
